// ===== design/midi_rx_pkg.sv =====
// Shared types and constants for the MIDI receive byte router.
// No dependencies; imported by midi_rx_classify, midi_receive_byte_router and the testbench.
package midi_rx_pkg;

  // Status byte values the router acts on
  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [7:0] BYTE_CLOCK       = 8'hF8;
  localparam logic [7:0] BYTE_START       = 8'hFA;
  localparam logic [7:0] BYTE_CONTINUE    = 8'hFB;
  localparam logic [7:0] BYTE_STOP        = 8'hFC;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_RECEIVER     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSPORT_RECEIVER = 2'd1;

  typedef enum logic [1:0] {
    TEV_NONE     = 2'd0,
    TEV_START    = 2'd1,
    TEV_STOP     = 2'd2,
    TEV_CONTINUE = 2'd3
  } transport_event_t;

  typedef enum logic [2:0] {
    SX_NONE  = 3'd0,
    SX_BEGIN = 3'd1,
    SX_DATA  = 3'd2,
    SX_END   = 3'd3,
    SX_ABORT = 3'd4
  } sysex_event_t;

  typedef struct packed {
    logic clock_receiver;
    logic transport_receiver;
  } port_cfg_t;

  typedef struct packed {
    logic             forward_valid;
    logic [7:0]       forward_byte;
    logic             clock_tick;
    transport_event_t transport_event;
    sysex_event_t     sysex_event;
    logic             dropped_error;
  } rx_result_t;

endpackage

// ===== design/midi_rx_classify.sv =====
// Combinational classifier: decides what happens to one received byte.
// Depends on midi_rx_pkg.
module midi_rx_classify (
  input  logic [7:0]             rx_byte,
  input  logic [3:0]             error_flags,
  input  logic                   in_sysex,
  input  midi_rx_pkg::port_cfg_t cfg,
  output midi_rx_pkg::rx_result_t result,
  output logic                   in_sysex_next
);
  import midi_rx_pkg::*;

  always_comb begin
    result = '{forward_valid:   1'b0,
               forward_byte:    rx_byte,
               clock_tick:      1'b0,
               transport_event: TEV_NONE,
               sysex_event:     SX_NONE,
               dropped_error:   1'b0};
    in_sysex_next = in_sysex;

    priority if (error_flags != 4'd0) begin
      result.dropped_error = 1'b1;
      result.forward_byte  = 8'd0;
    end else if (rx_byte >= BYTE_CLOCK) begin
      // realtime never touches the sysex run
      if (rx_byte == BYTE_CLOCK) begin
        result.clock_tick = cfg.clock_receiver;
      end else if (cfg.transport_receiver) begin
        result.forward_valid = 1'b1;
        priority if (rx_byte == BYTE_START)    result.transport_event = TEV_START;
        else if (rx_byte == BYTE_STOP)         result.transport_event = TEV_STOP;
        else if (rx_byte == BYTE_CONTINUE)     result.transport_event = TEV_CONTINUE;
        else                                   result.transport_event = TEV_NONE;
      end
    end else if (in_sysex) begin
      if (rx_byte[7]) begin
        in_sysex_next = 1'b0;
        if (rx_byte == BYTE_SYSEX_END) begin
          result.sysex_event = SX_END;
        end else begin
          // any other status aborts the run and goes on to the buffer
          result.sysex_event   = SX_ABORT;
          result.forward_valid = 1'b1;
        end
      end else begin
        result.sysex_event = SX_DATA;
      end
    end else if (rx_byte == BYTE_SYSEX_START) begin
      in_sysex_next      = 1'b1;
      result.sysex_event = SX_BEGIN;
    end else begin
      result.forward_valid = 1'b1;
    end
  end

endmodule

// ===== design/midi_receive_byte_router.sv =====
// Top level of the MIDI receive byte router: config registers, sysex state,
// result register. Depends on midi_rx_pkg and midi_rx_classify.
//
// Usage:
//   Input channel (in_valid/in_ready): one received serial word per item,
//   rx_byte plus error_flags. Output channel (out_valid/out_ready): exactly
//   one result item per input item, in order.
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 = clock_receiver,
//   1 = transport_receiver, bit 0 of cfg_data is stored; other indexes are
//   ignored. cfg_ready is always high. Write only while no item is in flight.
//   The result is registered: it appears in the cycle after the input is accepted.
//   Throughput: one item per cycle while out_ready is high; the classify logic and
//   the one-bit sysex state update both finish in the cycle the item is accepted.
//   Stall: the result register holds its item while out_ready is low; in_ready
//   stays high as long as that register is empty or being drained this cycle.
//   Reset (rst, synchronous): both config bits clear, the sysex run is closed
//   and the result register is emptied.
module midi_receive_byte_router (
  input  logic                               clk,
  input  logic                               rst,
  // config write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [midi_rx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                               cfg_data,
  // received words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  input  logic [3:0]                         error_flags,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               forward_valid,
  output logic [7:0]                         forward_byte,
  output logic                               clock_tick,
  output logic [1:0]                         transport_event,
  output logic [2:0]                         sysex_event,
  output logic                               dropped_error
);
  import midi_rx_pkg::*;

  port_cfg_t  cfg;
  logic       in_sysex;
  logic       in_sysex_next;
  rx_result_t result_next;
  rx_result_t result;
  logic       in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CLOCK_RECEIVER) begin
        cfg.clock_receiver <= cfg_data;
      end else if (cfg_index == CFG_TRANSPORT_RECEIVER) begin
        cfg.transport_receiver <= cfg_data;
      end
    end
  end

  midi_rx_classify u_classify (
    .rx_byte       (rx_byte),
    .error_flags   (error_flags),
    .in_sysex      (in_sysex),
    .cfg           (cfg),
    .result        (result_next),
    .in_sysex_next (in_sysex_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sysex  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        in_sysex <= in_sysex_next;
      end
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= result_next;
    end
  end

  assign forward_valid   = result.forward_valid;
  assign forward_byte    = result.forward_byte;
  assign clock_tick      = result.clock_tick;
  assign transport_event = result.transport_event;
  assign sysex_event     = result.sysex_event;
  assign dropped_error   = result.dropped_error;

endmodule

// ===== dv/tb_midi_receive_byte_router.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for midi_receive_byte_router: queue-fed driver,
// clocked monitor and an in-bench routing predictor. Depends on midi_rx_pkg and midi_receive_byte_router.
module tb_midi_receive_byte_router;
  import midi_rx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] flags;
  } rx_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic [3:0] error_flags = 4'h0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic forward_valid;
  logic [7:0] forward_byte;
  logic clock_tick;
  logic [1:0] transport_event;
  logic [2:0] sysex_event;
  logic dropped_error;

  midi_receive_byte_router DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .error_flags(error_flags),
    .out_valid(out_valid), .out_ready(out_ready), .forward_valid(forward_valid),
    .forward_byte(forward_byte), .clock_tick(clock_tick), .transport_event(transport_event),
    .sysex_event(sysex_event), .dropped_error(dropped_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rx_word_t   rx_words[$];   // words waiting to be driven
  rx_result_t routed_q[$];   // predicted results, oldest first

  // predictor copy of the port setup and sysex state
  logic port_clock_rx = 1'b0;
  logic port_transport_rx = 1'b0;
  logic sysex_open = 1'b0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_words = 0;
  int unsigned n_results = 0;
  int unsigned n_runs = 0;
  int unsigned n_dropped = 0;
  int unsigned n_settings = 0;

  int  in_gap = 0;
  int  out_stall = 0;
  bit  in_busy = 0;
  bit  in_taken = 0;
  bit  out_taken = 0;
  bit  quiet = 0;
  rx_word_t cur_word;
  rx_result_t want;

  function automatic rx_result_t route_byte(input logic [7:0] b, input logic [3:0] e);
    rx_result_t r;
    r = '0;
    r.forward_byte = b;
    if (e != 4'h0) begin
      r.dropped_error = 1'b1;
      r.forward_byte = 8'h00;
      n_dropped++;
    end else if (b >= BYTE_CLOCK) begin
      // realtime never touches the sysex run
      if (b == BYTE_CLOCK) begin
        r.clock_tick = port_clock_rx;
      end else if (port_transport_rx) begin
        r.forward_valid = 1'b1;
        unique case (b)
          BYTE_START:    r.transport_event = TEV_START;
          BYTE_STOP:     r.transport_event = TEV_STOP;
          BYTE_CONTINUE: r.transport_event = TEV_CONTINUE;
          default:       r.transport_event = TEV_NONE;
        endcase
      end
    end else if (sysex_open) begin
      if (b[7]) begin
        if (b == BYTE_SYSEX_END) begin
          r.sysex_event = SX_END;
        end else begin
          r.sysex_event = SX_ABORT;
          r.forward_valid = 1'b1;
        end
        sysex_open = 1'b0;
      end else begin
        r.sysex_event = SX_DATA;
      end
    end else if (b == BYTE_SYSEX_START) begin
      sysex_open = 1'b1;
      r.sysex_event = SX_BEGIN;
      n_runs++;
    end else begin
      r.forward_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (errors <= 10)
        $display("MISMATCH %s: expected %h, got %h (result %0d)", name, exp_v, act_v, n_results);
    end
  endtask

  // monitor, predictor and config mirror, all sampled at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) begin
        n_results++;
        out_taken = 1;
        if (routed_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("MISMATCH: result %0d arrived with nothing expected", n_results);
        end else begin
          want = routed_q.pop_front();
          check_field("forward_valid", 8'(want.forward_valid), 8'(forward_valid));
          check_field("forward_byte", want.forward_byte, forward_byte);
          check_field("clock_tick", 8'(want.clock_tick), 8'(clock_tick));
          check_field("transport_event", 8'(want.transport_event), 8'(transport_event));
          check_field("sysex_event", 8'(want.sysex_event), 8'(sysex_event));
          check_field("dropped_error", 8'(want.dropped_error), 8'(dropped_error));
        end
      end
      if (in_valid && in_ready) begin
        routed_q.push_back(route_byte(rx_byte, error_flags));
        n_words++;
        in_taken = 1;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLOCK_RECEIVER) port_clock_rx = cfg_data;
        else if (cfg_index == CFG_TRANSPORT_RECEIVER) port_transport_rx = cfg_data;
      end
    end
  end

  // input driver: random gap before each item, valid held until taken
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 0;
        in_busy = 0;
        in_gap = quiet ? 0 : $urandom_range(0, 9);
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (rx_words.size() != 0) begin
          cur_word = rx_words.pop_front();
          rx_byte <= cur_word.data;
          error_flags <= cur_word.flags;
          in_busy = 1;
        end
      end
      in_valid <= in_busy;
    end
  end

  // result side back-pressure, one stall drawn per item
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        out_taken = 0;
        out_stall = quiet ? 0 : $urandom_range(0, 9);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic [3:0] e);
    rx_word_t w;
    w.data = b;
    w.flags = e;
    rx_words.push_back(w);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (rx_words.size() != 0 || in_busy || routed_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // mostly well-formed traffic: sysex runs, channel messages, realtime, noise
  task automatic add_random_message();
    int kind;
    int n;
    kind = $urandom_range(0, 19);
    if (kind < 9) begin
      push_word(BYTE_SYSEX_START, 4'h0);
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) push_word(8'(8'hF8 + $urandom_range(0, 7)), 4'h0);
        if ($urandom_range(0, 19) == 0)
          push_word(8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)));
        push_word(8'($urandom_range(0, 127)), 4'h0);
      end
      case ($urandom_range(0, 5))
        0:       push_word(8'($urandom_range(8'h80, 8'hEF)), 4'h0);
        1:       push_word(8'($urandom_range(8'hF0, 8'hF6)), 4'h0);
        default: push_word(BYTE_SYSEX_END, 4'h0);
      endcase
    end else if (kind < 13) begin
      push_word(8'($urandom_range(8'h80, 8'hEF)), 4'h0);
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) push_word(8'($urandom_range(0, 127)), 4'h0);
    end else if (kind < 16) begin
      push_word(8'(8'hF8 + $urandom_range(0, 7)), 4'h0);
    end else if (kind < 18) begin
      push_word(8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)));
    end else begin
      push_word(8'($urandom_range(0, 255)),
                $urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setup: clock and transport bytes are not acted on
    n_settings++;
    push_word(BYTE_CLOCK, 4'h0);
    push_word(BYTE_START, 4'h0);
    push_word(8'hFF, 4'h0);
    wait_idle();

    // writes past the register list change nothing
    write_reg(CFG_SPARE_A, 1'b1);
    write_reg(CFG_SPARE_B, 1'b1);
    push_word(BYTE_CLOCK, 4'h0);
    wait_idle();

    write_reg(CFG_CLOCK_RECEIVER, 1'b1);
    write_reg(CFG_TRANSPORT_RECEIVER, 1'b1);
    n_settings++;
    push_word(8'h00, 4'h0);
    push_word(8'hFF, 4'h0);
    push_word(BYTE_SYSEX_END, 4'h0);     // end-of-exclusive outside a run
    push_word(BYTE_SYSEX_START, 4'h0);
    push_word(8'h7F, 4'h0);
    push_word(BYTE_CLOCK, 4'h0);         // realtime inside a run
    push_word(BYTE_STOP, 4'h0);
    push_word(8'hF9, 4'h0);
    push_word(BYTE_SYSEX_START, 4'hF);   // error word inside a run
    push_word(8'h41, 4'h0);
    push_word(BYTE_SYSEX_END, 4'h0);
    push_word(BYTE_SYSEX_START, 4'h0);
    push_word(8'h00, 4'h0);
    push_word(BYTE_SYSEX_START, 4'h0);   // start inside a run aborts it
    push_word(BYTE_SYSEX_START, 4'h0);
    push_word(8'h10, 4'h0);
    push_word(8'h90, 4'h0);              // channel status aborts
    push_word(BYTE_START, 4'h0);
    push_word(BYTE_CONTINUE, 4'h0);
    push_word(8'hFD, 4'h0);
    push_word(8'hFE, 4'h0);
    push_word(8'h80, 4'h1);
    push_word(8'h00, 4'h8);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if ($urandom_range(0, 1)) write_reg(CFG_SPARE_A, 1'($urandom_range(0, 1)));
      else write_reg(CFG_SPARE_B, 1'($urandom_range(0, 1)));
      write_reg(CFG_CLOCK_RECEIVER, p[0]);
      write_reg(CFG_TRANSPORT_RECEIVER, p[1]);
      n_settings++;
      quiet = (p == 3 || p == 6);
      while (rx_words.size() < 180) add_random_message();
      wait_idle();
    end

    if (routed_q.size() != 0) errors++;
    $display("Routed %0d words (%0d results checked) over %0d port setups;", n_words,
             n_results, n_settings);
    $display("  %0d sysex runs opened, %0d error words dropped.", n_runs, n_dropped);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/midi_rx_pkg.sv
design/midi_rx_classify.sv
design/midi_receive_byte_router.sv
dv/tb_midi_receive_byte_router.sv
